### rtl/bounded_deque_core_macros.svh
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Shared concurrent assertion wrappers for the bounded deque RTL. Defining
// ASSERT_OFF compiles every assertion away.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define BDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define BDQ_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDQ_ASSERT(label, clk, rst, prop, msg)
`define BDQ_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Operation codes, result status codes, controller states and the control
// bundle that the pointer unit hands to the top level.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DATA_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT  = 3'd0,
      OP_PUSH_BACK   = 3'd1,
      OP_WRITE_FRONT = 3'd2,
      OP_WRITE_BACK  = 3'd3,
      OP_POP_FRONT   = 3'd4,
      OP_POP_BACK    = 3'd5,
      OP_CLEAR       = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_READ = 1'b1
   } state_type;

   // Memory strobes are already qualified by the input handshake.
   typedef struct packed {
      logic       mem_wr;
      logic       mem_rd;
      status_type status;
   } ctrl_type;

endpackage

### rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// Bounded deque entry memory
// Single-port-write, single-port-read synchronous memory with a registered
// read port, so a read word appears in the cycle after its address.
// ----------------------------------------------------------------------------
module bdq_ram
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bdq_ptr.sv
// ----------------------------------------------------------------------------
// Bounded deque pointer unit
// Holds the front index and the fill count, decodes the operation, works out
// the entry address and the status, and updates both registers on a beat.
// ----------------------------------------------------------------------------
`include "bounded_deque_core_macros.svh"

module bdq_ptr
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [OPCODE_W-1:0] opcode,
   output ctrl_type            ctrl,
   output logic [AW-1:0]       wr_addr,
   output logic [AW-1:0]       rd_addr,
   output logic [CW-1:0]       count_next,
   output logic [CW-1:0]       count_now
);

   localparam int SW = AW + 1;

   logic [AW-1:0] front_ff;
   logic [AW-1:0] front_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic          empty;
   logic          full;
   logic [AW-1:0] front_dec;
   logic [AW-1:0] front_inc;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] back_sum;
   logic [SW-1:0] tail_wrap;
   logic [SW-1:0] back_wrap;
   logic [AW-1:0] tail_idx;
   logic [AW-1:0] back_idx;
   logic          do_wr;
   logic          do_rd;
   status_type    status;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   // Both sums stay below twice the depth whenever their index is used, so one conditional subtract wraps.
   assign tail_sum  = SW'(front_ff) + SW'(count_ff);
   assign back_sum  = tail_sum - SW'(1);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
   assign tail_idx  = tail_wrap[AW-1:0];
   assign back_idx  = back_wrap[AW-1:0];

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      wr_addr  = front_ff;
      rd_addr  = front_ff;
      do_wr    = 1'b0;
      do_rd    = 1'b0;
      status   = STATUS_OK;
      unique case (op_type'(opcode))
         OP_PUSH_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               do_wr    = 1'b1;
               wr_addr  = front_dec;
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               do_wr    = 1'b1;
               wr_addr  = tail_idx;
               count_in = count_ff + CW'(1);
            end
         end
         OP_WRITE_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               do_wr = 1'b1;
            end
         end
         OP_WRITE_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               do_wr   = 1'b1;
               wr_addr = back_idx;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               do_rd    = 1'b1;
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               do_rd    = 1'b1;
               rd_addr  = back_idx;
               count_in = count_ff - CW'(1);
            end
         end
         OP_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign ctrl.mem_wr = do_wr & accept;
   assign ctrl.mem_rd = do_rd & accept;
   assign ctrl.status = status;
   assign count_next  = count_in;
   assign count_now   = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   `BDQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "fill count above depth")
   `BDQ_ASSERT(a_rd_nonempty, clock, reset, ctrl.mem_rd |-> (count_ff != '0), "pop read on empty")
   `BDQ_ASSERT(a_front_bound, clock, reset, front_ff <= AW'(DEPTH - 1), "front index out of range")
   `BDQ_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> (count_ff == '0), "count not cleared")

endmodule

### rtl/bounded_deque_core.sv
// ----------------------------------------------------------------------------
// Bounded deque core
// Double-ended queue of signed 32-bit words kept as a ring in one
// synchronous memory, with one result beat for every request beat.
// ----------------------------------------------------------------------------
// A request beat carries an opcode in req_tuser and a word in req_tdata; each
// one produces exactly one response beat with a status, the popped word (zero
// unless a pop succeeded) and the occupancy after the operation. Pushes,
// overwrites, clear and the unused opcode finish in the cycle they are taken,
// so a stream of them runs at one beat per cycle while rsp_tready is high. A
// pop that finds data waits for the memory word, which arrives in the cycle
// after the address; no request is taken until it is loaded. A push into
// a full queue returns status full and is dropped; an overwrite or pop on an
// empty queue returns status empty and changes nothing. The response sits in
// an output register, so a new request is taken while an earlier response is
// still being drained, provided that register empties in the same cycle. No
// memory clearing pass is needed after reset: only entries inside the
// occupied ring are ever read, and each of them was written first.
// ----------------------------------------------------------------------------
`include "bounded_deque_core_macros.svh"

module bounded_deque_core
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1),
   localparam int RSP_W = ((DATA_W + CW + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [31:0] value
   input  logic [OPCODE_W-1:0] req_tuser,   // [2:0] opcode
   // Response channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // [31:0] popped_value, then occupancy
   output logic [STATUS_W-1:0] rsp_tuser    // [1:0] status
);

   ctrl_type      ctrl;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] count_next;
   logic [CW-1:0] count_now;
   logic [DATA_W-1:0] rd_data;

   state_type state_ff;
   state_type state_in;

   logic              out_valid_ff;
   logic              out_valid_in;
   status_type        out_status_ff;
   status_type        out_status_in;
   logic [DATA_W-1:0] out_popped_ff;
   logic [DATA_W-1:0] out_popped_in;
   logic [CW-1:0]     out_occ_ff;
   logic [CW-1:0]     out_occ_in;
   logic              out_load;

   logic out_free;
   logic accept;

   // The output register can take a new beat when it is empty or draining.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == STATE_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   bdq_ptr #(
      .DEPTH(DEPTH)
   ) u_ptr (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_tuser),
      .ctrl       (ctrl),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .count_next (count_next),
      .count_now  (count_now)
   );

   bdq_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.mem_wr),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (ctrl.mem_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Only one request is in flight, so while waiting on the memory the
   // pointer unit's count already holds the occupancy after the pop.
   always_comb begin
      state_in      = state_ff;
      out_load      = 1'b0;
      out_status_in = out_status_ff;
      out_popped_in = out_popped_ff;
      out_occ_in    = out_occ_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               if (ctrl.mem_rd) begin
                  state_in = STATE_READ;
               end else begin
                  out_load      = 1'b1;
                  out_status_in = ctrl.status;
                  out_popped_in = '0;
                  out_occ_in    = count_next;
               end
            end
         end
         STATE_READ: begin
            if (out_free) begin
               state_in      = STATE_IDLE;
               out_load      = 1'b1;
               out_status_in = STATUS_OK;
               out_popped_in = rd_data;
               out_occ_in    = count_now;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_popped_ff <= out_popped_in;
         out_occ_ff    <= out_occ_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{(RSP_W - DATA_W - CW){1'b0}}, out_occ_ff, out_popped_ff};

   `BDQ_ASSERT(a_pop_waits, clock, reset, ctrl.mem_rd |=> (state_ff == STATE_READ), "pop did not wait on memory")
   `BDQ_ASSERT(a_read_loads, clock, reset, (state_ff == STATE_READ && out_free) |=> (rsp_tvalid && rsp_tuser == STATUS_OK), "pop result not loaded")

endmodule
